FILE: hw/rtl/lbavg_pkg.sv
package lbavg_pkg;

    localparam int SAMPLE_W = 8;
    localparam int LEVEL_W  = 3;
    localparam int SLOT_W   = 4;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [SAMPLE_W-1:0] THR_ONE_RST   = 8'd40;
    localparam logic [SAMPLE_W-1:0] THR_TWO_RST   = 8'd90;
    localparam logic [SAMPLE_W-1:0] THR_THREE_RST = 8'd150;
    localparam logic [SAMPLE_W-1:0] THR_FOUR_RST  = 8'd220;

    typedef enum logic {
        MODE_SAMPLE = 1'b0,
        MODE_READ   = 1'b1
    } t_mode;

    typedef enum logic {
        KIND_AVG  = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        REG_THR_ONE   = 2'd0,
        REG_THR_TWO   = 2'd1,
        REG_THR_THREE = 2'd2,
        REG_THR_FOUR  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] one;
        logic [SAMPLE_W-1:0] two;
        logic [SAMPLE_W-1:0] three;
        logic [SAMPLE_W-1:0] four;
    } t_thr;

    // closed window: push its average into the history
    typedef struct packed {
        logic               push;
        logic [LEVEL_W-1:0] level;
    } t_push;

    // history read reply
    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] level;
    } t_rd;

endpackage

FILE: hw/rtl/lbavg_quant.sv
module lbavg_quant (
    input  logic [lbavg_pkg::SAMPLE_W-1:0] i_sample,
    input  lbavg_pkg::t_thr                i_thr,
    output logic [lbavg_pkg::LEVEL_W-1:0]  o_level
);

    // thresholds are tested in order; the first one not exceeded wins
    always_comb begin
        priority if (i_sample <= i_thr.one) begin
            o_level = 3'd0;
        end else if (i_sample <= i_thr.two) begin
            o_level = 3'd1;
        end else if (i_sample <= i_thr.three) begin
            o_level = 3'd2;
        end else if (i_sample <= i_thr.four) begin
            o_level = 3'd3;
        end else begin
            o_level = 3'd4;
        end
    end

endmodule

FILE: hw/rtl/lbavg_win.sv
module lbavg_win #(
    parameter int WINDOW_LEN = 59
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [lbavg_pkg::LEVEL_W-1:0] i_level,
    output lbavg_pkg::t_push              o_push
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W = $clog2(4 * WINDOW_LEN + 1);

    // round(sum / W), halves up: level k reached when 2*sum >= (2k-1)*W
    localparam logic [SUM_W:0] RND_1 = (SUM_W+1)'(WINDOW_LEN);
    localparam logic [SUM_W:0] RND_2 = (SUM_W+1)'(3 * WINDOW_LEN);
    localparam logic [SUM_W:0] RND_3 = (SUM_W+1)'(5 * WINDOW_LEN);
    localparam logic [SUM_W:0] RND_4 = (SUM_W+1)'(7 * WINDOW_LEN);

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W:0]   sum_x2;
    logic             full;
    logic [lbavg_pkg::LEVEL_W-1:0] avg;

    assign sum_x2 = {r_sum, 1'b0};
    assign full   = (r_count >= CNT_W'(WINDOW_LEN));

    always_comb begin
        priority if (sum_x2 >= RND_4) begin
            avg = 3'd4;
        end else if (sum_x2 >= RND_3) begin
            avg = 3'd3;
        end else if (sum_x2 >= RND_2) begin
            avg = 3'd2;
        end else if (sum_x2 >= RND_1) begin
            avg = 3'd1;
        end else begin
            avg = 3'd0;
        end
    end

    assign o_push.push  = i_step && full;
    assign o_push.level = avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_step) begin
            if (full) begin
                // start a new window with this level
                r_sum   <= SUM_W'(i_level);
                r_count <= CNT_W'(1);
            end else begin
                r_sum   <= r_sum + SUM_W'(i_level);
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/lbavg_hist.sv
module lbavg_hist #(
    parameter int HISTORY_LEN = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbavg_pkg::t_push             i_push,
    input  logic [lbavg_pkg::SLOT_W-1:0] i_slot,
    output lbavg_pkg::t_rd               o_rd
);

    localparam int FILL_W = $clog2(HISTORY_LEN + 1);
    localparam int IDX_W  = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int CMP_W  = (FILL_W > lbavg_pkg::SLOT_W) ? FILL_W : lbavg_pkg::SLOT_W;

    logic [lbavg_pkg::LEVEL_W-1:0] r_hist [HISTORY_LEN];
    logic [FILL_W-1:0]             r_fill;
    logic                          hit;

    // entries at or beyond the fill count are never read, so need no reset
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_hist[0] <= i_push.level;
            for (int i = 1; i < HISTORY_LEN; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_push.push && (r_fill != FILL_W'(HISTORY_LEN))) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    assign hit = (CMP_W'(i_slot) < CMP_W'(r_fill));

    assign o_rd.hit   = hit;
    assign o_rd.level = hit ? r_hist[i_slot[IDX_W-1:0]] : '0;

endmodule

FILE: hw/rtl/light_level_block_averager_core.sv
// Channel | Direction | Handshake                    | Payload
// --------+-----------+------------------------------+-----------------------------------------
// in      | to core   | i_in_valid / o_in_stall      | i_mode, i_raw_sample, i_history_slot
// out     | from core | o_out_valid / i_out_stall    | o_result_kind, o_average_level,
//         |           |                              | o_entry_valid
// cfg     | to core   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One word per cycle sustained while the output is not stalled. A word is held in the input
// register while the quantise/accumulate/round path works on it; its result (a read reply, or
// an average when the sample closes a window) is then registered in the result register.
// Reset is synchronous: thresholds return to 40/90/150/220, the window and history fill
// are cleared; history entries are masked by the fill count, not cleared.
// An output stall holds the result register and reaches o_in_stall only while the input
// register holds a word.
module light_level_block_averager_core #(
    parameter int WINDOW_LEN  = 59,
    parameter int HISTORY_LEN = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_mode,
    input  logic [lbavg_pkg::SAMPLE_W-1:0]      i_raw_sample,
    input  logic [lbavg_pkg::SLOT_W-1:0]        i_history_slot,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_result_kind,
    output logic [lbavg_pkg::LEVEL_W-1:0]       o_average_level,
    output logic                                o_entry_valid,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lbavg_pkg::ADDR_W-1:0]        paddr,
    input  logic [lbavg_pkg::DATA_W-1:0]        pwdata,
    output logic [lbavg_pkg::DATA_W-1:0]        prdata,
    output logic                                pready
);

    lbavg_pkg::t_thr r_thr;

    logic                              r_s1_valid;
    logic                              r_s1_mode;
    logic [lbavg_pkg::SAMPLE_W-1:0]    r_s1_sample;
    logic [lbavg_pkg::SLOT_W-1:0]      r_s1_slot;

    logic                              r_out_valid;
    logic                              r_out_kind;
    logic [lbavg_pkg::LEVEL_W-1:0]     r_out_level;
    logic                              r_out_entry;

    logic                              out_free;
    logic                              advance;
    logic                              is_read;
    logic                              produce;
    logic [lbavg_pkg::LEVEL_W-1:0]     level;
    lbavg_pkg::t_push                  push;
    lbavg_pkg::t_rd                    rd;
    lbavg_pkg::t_reg_idx               reg_idx;
    logic                              cfg_wr;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = lbavg_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.one   <= lbavg_pkg::THR_ONE_RST;
            r_thr.two   <= lbavg_pkg::THR_TWO_RST;
            r_thr.three <= lbavg_pkg::THR_THREE_RST;
            r_thr.four  <= lbavg_pkg::THR_FOUR_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                lbavg_pkg::REG_THR_ONE:   r_thr.one   <= pwdata[7:0];
                lbavg_pkg::REG_THR_TWO:   r_thr.two   <= pwdata[7:0];
                lbavg_pkg::REG_THR_THREE: r_thr.three <= pwdata[7:0];
                lbavg_pkg::REG_THR_FOUR:  r_thr.four  <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lbavg_pkg::REG_THR_ONE:   prdata = lbavg_pkg::DATA_W'(r_thr.one);
            lbavg_pkg::REG_THR_TWO:   prdata = lbavg_pkg::DATA_W'(r_thr.two);
            lbavg_pkg::REG_THR_THREE: prdata = lbavg_pkg::DATA_W'(r_thr.three);
            lbavg_pkg::REG_THR_FOUR:  prdata = lbavg_pkg::DATA_W'(r_thr.four);
        endcase
    end

    // flow control
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_mode   <= i_mode;
            r_s1_sample <= i_raw_sample;
            r_s1_slot   <= i_history_slot;
        end
    end

    assign is_read = (r_s1_mode == lbavg_pkg::MODE_READ);

    lbavg_quant u_quant (
        .i_sample (r_s1_sample),
        .i_thr    (r_thr),
        .o_level  (level)
    );

    lbavg_win #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance && !is_read),
        .i_level (level),
        .o_push  (push)
    );

    lbavg_hist #(
        .HISTORY_LEN (HISTORY_LEN)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_slot  (r_s1_slot),
        .o_rd    (rd)
    );

    assign produce = advance && (is_read || push.push);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            if (is_read) begin
                r_out_kind  <= lbavg_pkg::KIND_READ;
                r_out_level <= rd.level;
                r_out_entry <= rd.hit;
            end else begin
                r_out_kind  <= lbavg_pkg::KIND_AVG;
                r_out_level <= push.level;
                r_out_entry <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_average_level = r_out_level;
    assign o_entry_valid   = r_out_entry;

endmodule

FILE: hw/rtl/lbavg_chk.sv
module lbavg_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic                          o_result_kind,
    input logic [lbavg_pkg::LEVEL_W-1:0] o_average_level,
    input logic                          o_entry_valid
);

    // reset empties both the input and the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("core not empty after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_avg_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == lbavg_pkg::KIND_AVG) |-> o_entry_valid)
        else $error("window average marked invalid");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_average_level <= 3'd4))
        else $error("level out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_entry_valid |->
            (o_average_level == 3'd0) && (o_result_kind == lbavg_pkg::KIND_READ))
        else $error("empty history reply not cleared");

endmodule

bind light_level_block_averager_core lbavg_chk u_lbavg_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_result_kind   (o_result_kind),
    .o_average_level (o_average_level),
    .o_entry_valid   (o_entry_valid)
);
